// File: design/mvm_pkg.sv
// shared types, constants and codes for the matrix-vector multiply block
package mvm_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int VALUE_W    = 32;
    localparam int SEL_W      = 4;
    localparam int REG_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W      = 64;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    localparam logic [REG_W-1:0] REG_RESET   = 5'd16;
    localparam logic [REG_W-1:0] COUNT_LIMIT = 5'd31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 4'd1;

    // request codes
    localparam logic REQ_MATRIX = 1'b0;
    localparam logic REQ_VECTOR = 1'b1;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    localparam logic signed [VALUE_W-1:0] DOT_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] DOT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_MAT_WR,
        CMD_VEC_WR,
        CMD_VEC_RUN,
        CMD_MISMATCH
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [SEL_W-1:0]   row_sel;
        logic [SEL_W-1:0]   col_sel;
        logic [REG_W-1:0]   idx;
        logic [REG_W-1:0]   rows;
        logic [REG_W-1:0]   cols;
        logic [VALUE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [SEL_W-1:0]          row_index;
        logic signed [VALUE_W-1:0] dot_value;
        logic                      saturated;
        logic                      status;
        logic                      last_result;
    } res_t;

endpackage

// File: design/mvm_ram.sv
// generic single-write, single-read ram with registered read data
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/mvm_fifo.sv
// small first-word fall-through queue
module mvm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: design/mvm_front.sv
// front end: config registers, vector count and item classification
module mvm_front #(
    parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             push,
    input  logic                             req_type,
    input  logic [mvm_pkg::SEL_W-1:0]        row_sel,
    input  logic [mvm_pkg::SEL_W-1:0]        col_sel,
    input  logic signed [mvm_pkg::VALUE_W-1:0] value,
    input  logic                             is_final,
    input  logic                             cmd_full,
    output logic                             cmd_push,
    output mvm_pkg::cmd_t                    cmd_item
);

    import mvm_pkg::*;

    logic [REG_W-1:0] row_count_reg, row_count_next;
    logic [REG_W-1:0] column_count_reg, column_count_next;
    logic [REG_W-1:0] count_reg, count_next;
    logic [REG_W-1:0] rows_eff;
    logic [REG_W-1:0] cols_eff;
    logic [REG_W-1:0] count_inc;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !cmd_full;

    // clamp registers into 1..MAX_DIM
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = REG_W'(1);
        end
        else if (int'(row_count_reg) > MAX_DIM)
        begin
            rows_eff = REG_W'(MAX_DIM);
        end
        else
        begin
            rows_eff = row_count_reg;
        end
        if (column_count_reg == '0)
        begin
            cols_eff = REG_W'(1);
        end
        else if (int'(column_count_reg) > MAX_DIM)
        begin
            cols_eff = REG_W'(MAX_DIM);
        end
        else
        begin
            cols_eff = column_count_reg;
        end
    end

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_COUNT:    row_count_next    = cfg_data[REG_W-1:0];
                REG_COLUMN_COUNT: column_count_next = cfg_data[REG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        count_inc        = (count_reg == COUNT_LIMIT) ? count_reg : count_reg + REG_W'(1);
        count_next       = count_reg;
        cmd_push         = 1'b0;
        cmd_item.op      = CMD_MAT_WR;
        cmd_item.row_sel = row_sel;
        cmd_item.col_sel = col_sel;
        cmd_item.idx     = count_reg;
        cmd_item.rows    = rows_eff;
        cmd_item.cols    = cols_eff;
        cmd_item.data    = value;
        if (accept)
        begin
            if (req_type == REQ_MATRIX)
            begin
                // writes outside the active size are dropped here
                cmd_push = (REG_W'(row_sel) < rows_eff) && (REG_W'(col_sel) < cols_eff);
            end
            else if (!is_final)
            begin
                cmd_item.op = CMD_VEC_WR;
                cmd_push    = (int'(count_reg) < MAX_DIM);
                count_next  = count_inc;
            end
            else
            begin
                cmd_item.op = (count_inc == cols_eff) ? CMD_VEC_RUN : CMD_MISMATCH;
                cmd_push    = 1'b1;
                count_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= REG_RESET;
            column_count_reg <= REG_RESET;
            count_reg        <= '0;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            count_reg        <= count_next;
        end
    end

endmodule

// File: design/mvm_back.sv
// back end: matrix and vector stores, shared multiply-accumulate, result build
module mvm_back #(
    parameter int MAX_DIM   = mvm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mvm_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  mvm_pkg::cmd_t cmd_item,
    output logic          cmd_pop,
    input  logic          res_full,
    output logic          res_push,
    output mvm_pkg::res_t res_item
);

    import mvm_pkg::*;

    localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int VEC_AW    = $clog2(MAX_DIM);

    back_state_t state_reg, state_next;

    logic [REG_W-1:0]  rows_reg, rows_next;
    logic [REG_W-1:0]  cols_reg, cols_next;
    logic [REG_W-1:0]  row_reg, row_next;
    logic [REG_W-1:0]  col_reg, col_next;
    logic [REG_W-1:0]  row_inc;
    logic [REG_W-1:0]  col_inc;
    logic [MAT_AW-1:0] base_reg, base_next;
    logic              mismatch_reg, mismatch_next;

    logic rd_vld_reg, rd_vld_next;
    logic rd_last_reg, rd_last_next;
    logic mul_vld_reg, mul_last_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] prod_shift;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic                    acc_fits;

    logic              mat_we;
    logic [MAT_AW-1:0] mat_waddr;
    logic [MAT_AW-1:0] mat_raddr;
    logic [VALUE_W-1:0] mat_rdata;
    logic              vec_we;
    logic [VEC_AW-1:0] vec_waddr;
    logic [VEC_AW-1:0] vec_raddr;
    logic [VALUE_W-1:0] vec_rdata;

    mvm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (cmd_item.data),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    mvm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (cmd_item.data),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    assign mat_waddr = MAT_AW'(cmd_item.row_sel) * MAT_AW'(MAX_DIM) + MAT_AW'(cmd_item.col_sel);
    assign vec_waddr = VEC_AW'(cmd_item.idx);
    assign mat_raddr = base_reg + MAT_AW'(col_reg);
    assign vec_raddr = VEC_AW'(col_reg);
    assign row_inc   = row_reg + REG_W'(1);
    assign col_inc   = col_reg + REG_W'(1);

    // floor shift of the product, then saturating 64-bit add
    always_comb
    begin
        prod_shift = prod_reg >>> FRAC_BITS;
        acc_sum    = {acc_reg[ACC_W-1], acc_reg} + {prod_shift[ACC_W-1], prod_shift};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // result word, clipped to 32 bits
    always_comb
    begin
        acc_fits = (&acc_reg[ACC_W-1:VALUE_W-1]) || !(|acc_reg[ACC_W-1:VALUE_W-1]);
        if (mismatch_reg)
        begin
            res_item.row_index   = '0;
            res_item.dot_value   = '0;
            res_item.saturated   = 1'b0;
            res_item.status      = STATUS_MISMATCH;
            res_item.last_result = 1'b1;
        end
        else
        begin
            res_item.row_index   = SEL_W'(row_reg);
            res_item.saturated   = !acc_fits;
            res_item.status      = STATUS_OK;
            res_item.last_result = (row_inc == rows_reg);
            if (acc_fits)
            begin
                res_item.dot_value = acc_reg[VALUE_W-1:0];
            end
            else
            begin
                res_item.dot_value = acc_reg[ACC_W-1] ? DOT_MIN : DOT_MAX;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        mismatch_next = mismatch_reg;
        acc_next      = mul_vld_reg ? acc_sat : acc_reg;
        rd_vld_next   = 1'b0;
        rd_last_next  = 1'b0;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        mat_we        = 1'b0;
        vec_we        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_item.op)
                        CMD_MAT_WR:
                        begin
                            mat_we = 1'b1;
                        end
                        CMD_VEC_WR:
                        begin
                            vec_we = 1'b1;
                        end
                        CMD_VEC_RUN:
                        begin
                            vec_we        = 1'b1;
                            rows_next     = cmd_item.rows;
                            cols_next     = cmd_item.cols;
                            row_next      = '0;
                            col_next      = '0;
                            base_next     = '0;
                            acc_next      = '0;
                            mismatch_next = 1'b0;
                            state_next    = BK_RUN;
                        end
                        CMD_MISMATCH:
                        begin
                            mismatch_next = 1'b1;
                            state_next    = BK_EMIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_RUN:
            begin
                rd_vld_next  = 1'b1;
                rd_last_next = (col_inc == cols_reg);
                if (col_inc == cols_reg)
                begin
                    col_next   = '0;
                    state_next = BK_DRAIN;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
            BK_DRAIN:
            begin
                if (mul_vld_reg && mul_last_reg)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (mismatch_reg || row_inc == rows_reg)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        row_next   = row_inc;
                        base_next  = base_reg + MAT_AW'(MAX_DIM);
                        acc_next   = '0;
                        state_next = BK_RUN;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            rows_reg     <= '0;
            cols_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            mismatch_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            mul_vld_reg  <= 1'b0;
            mul_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            mismatch_reg <= mismatch_next;
            rd_vld_reg   <= rd_vld_next;
            rd_last_reg  <= rd_last_next;
            mul_vld_reg  <= rd_vld_reg;
            mul_last_reg <= rd_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(mat_rdata) * $signed(vec_rdata);
        acc_reg  <= acc_next;
    end

endmodule

// File: design/matrix_vector_multiply.sv
// top level of the dense matrix-vector multiply block
// Holds a matrix of up to MAX_DIM by MAX_DIM signed Q16.16 entries, written one
// entry per item, and multiplies it by a vector whose elements arrive one per
// item in column order; the element flagged is_final starts the job. Each row
// gives one result item in row order, the last flagged, or a single mismatch
// item when the element count differs from the column count. A front end takes
// one item per cycle while the command queue has room (config clamp, element
// count, filtering of out-of-size writes) and posts a command into a four-deep
// queue; full rises only when that queue is full. The back end runs one command
// at a time: a job runs every row through one shared 32x32 multiplier and
// 64-bit accumulator, one column per cycle, through a read, multiply and add
// pipeline, and then emits the row's result. Results wait in a two-deep queue,
// so a slow consumer stalls the back end first and the input only once the
// command queue fills. Stores need no clearing after reset; reading a
// never-written matrix entry gives undefined data.
module matrix_vector_multiply #(
    parameter int MAX_DIM   = mvm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mvm_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input items
    input  logic                               push,
    output logic                               full,
    input  logic                               req_type,
    input  logic [mvm_pkg::SEL_W-1:0]          row_sel,
    input  logic [mvm_pkg::SEL_W-1:0]          col_sel,
    input  logic signed [mvm_pkg::VALUE_W-1:0] value,
    input  logic                               is_final,
    // result items
    output logic                               empty,
    input  logic                               pop,
    output logic [mvm_pkg::SEL_W-1:0]          row_index,
    output logic signed [mvm_pkg::VALUE_W-1:0] dot_value,
    output logic                               saturated,
    output logic                               status,
    output logic                               last_result
);

    import mvm_pkg::*;

    // front to command queue
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;

    // command queue to back end
    logic cmd_pop;
    cmd_t cmd_out;
    logic cmd_empty;

    // back end to result queue
    logic res_push;
    res_t res_in;
    logic res_full;
    res_t res_out;

    assign full = cmd_full;

    mvm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .req_type  (req_type),
        .row_sel   (row_sel),
        .col_sel   (col_sel),
        .value     (value),
        .is_final  (is_final),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_item  (cmd_in)
    );

    // decouples item intake from the multiply-accumulate work
    mvm_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    mvm_back #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_item  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_in)
    );

    // result queue: head item sits on the result ports
    mvm_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign row_index   = res_out.row_index;
    assign dot_value   = res_out.dot_value;
    assign saturated   = res_out.saturated;
    assign status      = res_out.status;
    assign last_result = res_out.last_result;

    // back end never offers a result into a full queue
    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result pushed into full queue");

    // back end only takes a command that is there
    a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    // a mismatch result is always a lone zero item closing the vector
    a_mismatch_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == STATUS_MISMATCH) |->
            (last_result && dot_value == '0 && !saturated && row_index == '0))
        else $error("malformed mismatch result");

endmodule
